/* src/lcebp_pkg.sv */
// shared types and constants for the letter code encoder / bit packer
// depends on nothing; used by every module of the block except lcebp_ram
package lcebp_pkg;

    // default sizes
    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int MAX_CODE_LEN_DEF  = 25;

    // fixed field widths
    localparam int CODE_W  = 25;
    localparam int LEN_W   = 5;
    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam int ACC_W   = 32;
    localparam int HAVE_W  = 6;
    localparam int TOTAL_W = 32;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // index of the last byte one letter may complete (four bytes at most)
    localparam logic [1:0] LAST_EMIT = 2'd3;

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    // letter range
    localparam logic [7:0] LETTER_FIRST = 8'd65;
    localparam logic [7:0] LETTER_LAST  = 8'd90;

    typedef struct packed {
        logic              command;
        logic [7:0]        text_byte;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         packed_byte;
        logic               byte_valid;
        logic [TOTAL_W-1:0] total_bits;
        logic               last;
    } t_out_word;

    // work handed from front to back
    typedef struct packed {
        logic              is_end;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } t_op;

endpackage

/* src/letter_code_encoder_bit_packer.sv */
// top level of the letter code encoder with lsb-first bit packing
// depends on lcebp_pkg, lcebp_front, lcebp_fifo, lcebp_back (and lcebp_ram)
//
//   channel   | handshake          | word                | moves when
//   ----------+--------------------+---------------------+--------------------
//   input     | push in, full out  | i_in_word t_in_word | push && !full
//   result    | empty out, pop in  | o_out_word          | pop && !empty
//
// a word is taken every cycle while full is low; a load writes the table at
// its accepting edge, an encode word passes a lookup stage and a four entry queue
// the packer adds a letter's code to its pending bits, then emits each completed
// byte (four at most a letter) before it takes the next operation; an end marker flushes the rest
// full rises only when the queue is full and the lookup stage holds a word;
// reset clears pending bits, bit count and valid state, not the code table
module letter_code_encoder_bit_packer #(
    parameter int ALPHABET_SIZE = lcebp_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_CODE_LEN  = lcebp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  lcebp_pkg::t_in_word  i_in_word,
    output logic                 empty,
    input  logic                 pop,
    output lcebp_pkg::t_out_word o_out_word
);

    // front to queue
    logic           op_push;
    lcebp_pkg::t_op op_in;
    logic           op_full;

    // queue to back
    logic           op_valid;
    lcebp_pkg::t_op op_head;
    logic           op_pop;

    // table writes and letter lookup
    lcebp_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_word (i_in_word),
        .o_full    (full),
        .o_op_push (op_push),
        .o_op      (op_in),
        .i_op_full (op_full)
    );

    // decouples lookup from packing
    lcebp_fifo #(
        .DEPTH (lcebp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .o_full  (op_full),
        .o_valid (op_valid),
        .o_data  (op_head),
        .i_pop   (op_pop)
    );

    // packing, flush and bit count
    lcebp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op_head),
        .o_op_pop   (op_pop),
        .o_empty    (empty),
        .o_out_word (o_out_word),
        .i_pop      (pop)
    );

endmodule

/* src/lcebp_ram.sv */
// generic single write port, single read port ram with registered read
// depends on nothing
module lcebp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/lcebp_front.sv */
// front part: takes words, writes the code table, looks up letters, classifies
// depends on lcebp_pkg and lcebp_ram
module lcebp_front #(
    parameter int ALPHABET_SIZE = lcebp_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_CODE_LEN  = lcebp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lcebp_pkg::t_in_word i_in_word,
    output logic                o_full,
    output logic                o_op_push,
    output lcebp_pkg::t_op      o_op,
    input  logic                i_op_full
);

    localparam int IDX_W = $clog2(ALPHABET_SIZE);

    logic                          accept;
    logic                          is_load;
    logic                          in_table;
    logic                          is_letter;
    logic [7:0]                    letter_idx;
    logic [lcebp_pkg::LEN_W-1:0]   sat_len;
    logic [lcebp_pkg::CODE_W-1:0]  len_mask;
    logic [lcebp_pkg::ENTRY_W-1:0] wr_entry;
    logic [lcebp_pkg::ENTRY_W-1:0] rd_entry;
    logic                          stage_move;
    logic                          r_s1_valid;
    logic                          r_s1_letter;

    assign accept     = i_push && !o_full;
    assign is_load    = (i_in_word.command == lcebp_pkg::CMD_LOAD);
    assign in_table   = ({1'b0, i_in_word.text_byte} < 9'(ALPHABET_SIZE));
    assign letter_idx = i_in_word.text_byte - lcebp_pkg::LETTER_FIRST;
    assign is_letter  = (i_in_word.text_byte >= lcebp_pkg::LETTER_FIRST)
                     && (i_in_word.text_byte <= lcebp_pkg::LETTER_LAST)
                     && ({1'b0, letter_idx} < 9'(ALPHABET_SIZE));

    // saturate the length and drop code bits above it
    always_comb begin
        if ({1'b0, i_in_word.code_length} > 6'(MAX_CODE_LEN)) begin
            sat_len = lcebp_pkg::LEN_W'(MAX_CODE_LEN);
        end else begin
            sat_len = i_in_word.code_length;
        end
        for (int i = 0; i < lcebp_pkg::CODE_W; i++) begin
            len_mask[i] = (lcebp_pkg::LEN_W'(i) < sat_len);
        end
    end

    assign wr_entry = {i_in_word.code_bits & len_mask, sat_len};

    lcebp_ram #(
        .WIDTH (lcebp_pkg::ENTRY_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (accept && is_load && in_table),
        .i_wr_addr (i_in_word.text_byte[IDX_W-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (accept && !is_load && is_letter),
        .i_rd_addr (letter_idx[IDX_W-1:0]),
        .o_rd_data (rd_entry)
    );

    // lookup stage holds while the queue is full
    assign stage_move = !r_s1_valid || !i_op_full;
    assign o_full     = !stage_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_letter <= 1'b0;
        end else if (stage_move) begin
            r_s1_valid  <= accept && !is_load;
            r_s1_letter <= is_letter;
        end
    end

    assign o_op_push        = r_s1_valid && !i_op_full;
    assign o_op.is_end      = !r_s1_letter;
    assign o_op.code_bits   = rd_entry[lcebp_pkg::ENTRY_W-1:lcebp_pkg::LEN_W];
    assign o_op.code_length = rd_entry[lcebp_pkg::LEN_W-1:0];

endmodule

/* src/lcebp_fifo.sv */
// short queue of letter and end operations between front and back
// depends on lcebp_pkg
module lcebp_fifo #(
    parameter int DEPTH = lcebp_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lcebp_pkg::t_op i_data,
    output logic           o_full,
    output logic           o_valid,
    output lcebp_pkg::t_op o_data,
    input  logic           i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcebp_pkg::t_op   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/lcebp_back.sv */
// back part: bit packer, byte emission, end flush and bit count
// depends on lcebp_pkg
module lcebp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_op_valid,
    input  lcebp_pkg::t_op       i_op,
    output logic                 o_op_pop,
    output logic                 o_empty,
    output lcebp_pkg::t_out_word o_out_word,
    input  logic                 i_pop
);

    logic [lcebp_pkg::ACC_W-1:0]   r_acc;
    logic [lcebp_pkg::HAVE_W-1:0]  r_have;
    logic [1:0]                    r_nemit;
    logic [lcebp_pkg::TOTAL_W-1:0] r_total;
    logic                          r_out_valid;
    lcebp_pkg::t_out_word          r_out;

    logic [lcebp_pkg::ACC_W-1:0]   n_acc;
    logic [lcebp_pkg::HAVE_W-1:0]  n_have;
    logic [1:0]                    n_nemit;
    logic [lcebp_pkg::TOTAL_W-1:0] n_total;
    logic                          n_out_valid;
    lcebp_pkg::t_out_word          n_out;

    logic                          out_free;
    logic                          emitting;
    logic [lcebp_pkg::HAVE_W-1:0]  have_left;
    logic [lcebp_pkg::TOTAL_W:0]   total_sum;

    assign out_free  = !r_out_valid || i_pop;
    assign emitting  = (r_have[lcebp_pkg::HAVE_W-1:3] != '0);
    assign have_left = r_have - 6'd8;
    assign total_sum = {1'b0, r_total} + {28'd0, i_op.code_length};

    always_comb begin
        n_acc       = r_acc;
        n_have      = r_have;
        n_nemit     = r_nemit;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        o_op_pop    = 1'b0;
        if (emitting) begin
            if (out_free) begin
                n_out_valid       = 1'b1;
                n_out.packed_byte = r_acc[7:0];
                n_out.byte_valid  = 1'b1;
                n_out.total_bits  = '0;
                n_out.last        = 1'b0;
                n_acc             = r_acc >> 8;
                n_nemit           = r_nemit + 1'b1;
                // stop after the fourth byte of one letter
                if (have_left[lcebp_pkg::HAVE_W-1:3] != '0 && r_nemit != lcebp_pkg::LAST_EMIT) begin
                    n_have = have_left;
                end else begin
                    n_have = {3'd0, have_left[2:0]};
                end
            end
        end else if (i_op_valid) begin
            if (i_op.is_end) begin
                if (out_free) begin
                    o_op_pop          = 1'b1;
                    n_out_valid       = 1'b1;
                    n_out.byte_valid  = (r_have != '0);
                    n_out.packed_byte = (r_have != '0) ? r_acc[7:0] : 8'd0;
                    n_out.total_bits  = r_total;
                    n_out.last        = 1'b1;
                    n_acc             = '0;
                    n_have            = '0;
                    n_total           = '0;
                end
            end else begin
                o_op_pop = 1'b1;
                n_acc    = r_acc | ({7'd0, i_op.code_bits} << r_have[2:0]);
                n_have   = r_have + {1'b0, i_op.code_length};
                n_nemit  = '0;
                n_total  = total_sum[lcebp_pkg::TOTAL_W]
                         ? '1 : total_sum[lcebp_pkg::TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_have      <= '0;
            r_nemit     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_have      <= n_have;
            r_nemit     <= n_nemit;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out;

endmodule
